// ----- rtl/core/ffc_pkg.sv -----
// Format codes, constants and conversion functions for the float format converter.
package ffc_pkg;

  localparam logic       ACT_WIDEN  = 1'b0;
  localparam logic       ACT_NARROW = 1'b1;

  localparam logic [1:0] FMT_FP32 = 2'd0;
  localparam logic [1:0] FMT_FP16 = 2'd1;
  localparam logic [1:0] FMT_BF16 = 2'd2;
  localparam logic [1:0] FMT_E4M3 = 2'd3;

  localparam logic [7:0]  FP32_EXP_MAX   = 8'hff;
  localparam logic [7:0]  FP16_BIAS_ADJ  = 8'd112;
  localparam logic [7:0]  E4M3_BIAS_ADJ  = 8'd120;
  localparam logic [7:0]  FP16_EXP_OVF   = 8'd143;
  localparam logic [7:0]  E4M3_EXP_TOP   = 8'd135;
  localparam logic [31:0] FP32_NAN_CODE  = 32'h7fffffff;
  localparam logic [9:0]  FP16_QNAN_MANT = 10'h200;
  localparam logic [2:0]  E4M3_MANT_SAT  = 3'h6;

  function automatic logic [31:0] widen_fp16(input logic [15:0] v);
    logic       sign;
    logic [4:0] exp;
    logic [9:0] mant;
    logic [3:0] msb;
    logic [3:0] shift;
    logic [10:0] norm;
    logic [7:0] e;
    sign = v[15];
    exp  = v[14:10];
    mant = v[9:0];
    msb  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) msb = 4'(i);
    end
    shift = 4'd10 - msb;
    norm  = {1'b0, mant} << shift;
    e     = FP16_BIAS_ADJ + 8'd1 - {4'd0, shift};
    if (exp == 5'd0) begin
      if (mant == 10'd0) widen_fp16 = {sign, 31'd0};
      else               widen_fp16 = {sign, e, norm[9:0], 13'd0};
    end else if (exp == 5'h1f) begin
      widen_fp16 = {sign, FP32_EXP_MAX, mant, 13'd0};
    end else begin
      widen_fp16 = {sign, {3'd0, exp} + FP16_BIAS_ADJ, mant, 13'd0};
    end
  endfunction

  function automatic logic [31:0] widen_e4m3(input logic [7:0] v);
    logic       sign;
    logic [3:0] exp;
    logic [2:0] mant;
    logic [1:0] shift;
    logic [3:0] norm;
    logic [7:0] e;
    sign = v[7];
    exp  = v[6:3];
    mant = v[2:0];
    if (mant[2])      shift = 2'd1;
    else if (mant[1]) shift = 2'd2;
    else              shift = 2'd3;
    norm = {1'b0, mant} << shift;
    e    = E4M3_BIAS_ADJ + 8'd1 - {6'd0, shift};
    if (exp == 4'd0) begin
      if (mant == 3'd0) widen_e4m3 = {sign, 31'd0};
      else              widen_e4m3 = {sign, e, norm[2:0], 20'd0};
    end else if (exp == 4'hf && mant == 3'h7) begin
      widen_e4m3 = FP32_NAN_CODE;
    end else begin
      widen_e4m3 = {sign, {4'd0, exp} + E4M3_BIAS_ADJ, mant, 20'd0};
    end
  endfunction

  function automatic logic [15:0] narrow_fp16(input logic [31:0] f);
    logic       sign;
    logic [7:0] exp;
    logic [7:0] e;
    sign = f[31];
    exp  = f[30:23];
    e    = exp - FP16_BIAS_ADJ;
    if (exp == 8'd0 || exp <= FP16_BIAS_ADJ) begin
      narrow_fp16 = {sign, 15'd0};
    end else if (exp == FP32_EXP_MAX) begin
      narrow_fp16 = {sign, 5'h1f, (f[22:0] != 23'd0) ? FP16_QNAN_MANT : 10'd0};
    end else if (exp >= FP16_EXP_OVF) begin
      narrow_fp16 = {sign, 5'h1f, 10'd0};
    end else begin
      narrow_fp16 = {sign, e[4:0], f[22:13]};
    end
  endfunction

  function automatic logic [7:0] narrow_e4m3(input logic [31:0] f);
    logic       sign;
    logic [7:0] exp;
    logic [7:0] e;
    logic [2:0] m3;
    sign = f[31];
    exp  = f[30:23];
    e    = exp - E4M3_BIAS_ADJ;
    m3   = f[22:20];
    if (exp == E4M3_EXP_TOP && m3 > E4M3_MANT_SAT) m3 = E4M3_MANT_SAT;
    if (exp == 8'd0 || exp <= E4M3_BIAS_ADJ) begin
      narrow_e4m3 = {sign, 7'd0};
    end else if (exp == FP32_EXP_MAX) begin
      narrow_e4m3 = {sign, 7'h7f};
    end else if (exp > E4M3_EXP_TOP) begin
      narrow_e4m3 = {sign, 4'hf, E4M3_MANT_SAT};
    end else begin
      narrow_e4m3 = {sign, e[3:0], m3};
    end
  endfunction

endpackage

// ----- rtl/core/float_format_converter_top.sv -----
// Float format converter: FP32 to and from FP16, BF16 and FP8 E4M3 bit patterns.
// One transaction is accepted in every cycle; busy stays low. The input is
// registered, converted by one pass of logic and registered again, so each
// result is on out_result_bits with out_strobe high for exactly one cycle,
// in order of acceptance, once its transaction has passed both registers.
// The receiver must take every result in that cycle.
module float_format_converter_top
  import ffc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [1:0]  in_format,
  input  logic [31:0] in_value_bits,
  output logic        out_strobe,
  output logic [31:0] out_result_bits
);

  logic        valid_r;
  logic        action_r;
  logic [1:0]  format_r;
  logic [31:0] value_r;
  logic        strobe_r;
  logic [31:0] result_r;
  logic [31:0] result_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      valid_r  <= start & ~busy;
      strobe_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= in_action;
    format_r <= in_format;
    value_r  <= in_value_bits;
    result_r <= result_nxt;
  end

  always_comb begin
    if (action_r == ACT_WIDEN) begin
      case (format_r)
        FMT_FP16: result_nxt = widen_fp16(value_r[15:0]);
        FMT_BF16: result_nxt = {value_r[15:0], 16'd0};
        FMT_E4M3: result_nxt = widen_e4m3(value_r[7:0]);
        default:  result_nxt = value_r;
      endcase
    end else begin
      case (format_r)
        FMT_FP16: result_nxt = {16'd0, narrow_fp16(value_r)};
        FMT_BF16: result_nxt = {16'd0, value_r[31:16]};
        FMT_E4M3: result_nxt = {24'd0, narrow_e4m3(value_r)};
        default:  result_nxt = value_r;
      endcase
    end
  end

  assign out_strobe      = strobe_r;
  assign out_result_bits = result_r;

endmodule

// ----- bench/conversion_checker.sv -----
// Result checker for the float format converter: predicts each conversion and compares.
`timescale 1ns / 100ps

module conversion_checker
  import ffc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [1:0]  in_format,
  input  logic [31:0] in_value_bits,
  input  logic        out_strobe,
  input  logic [31:0] out_result_bits,
  output int          fault_count,
  output int          results_pending
);

  typedef struct packed {
    logic        action;
    logic [1:0]  format;
    logic [31:0] operand;
    logic [31:0] converted;
  } conversion_t;

  conversion_t awaited_conversions[$];
  conversion_t oldest;
  int          faults = 0;
  int          outstanding = 0;

  assign fault_count     = faults;
  assign results_pending = outstanding;

  function automatic logic [31:0] widen_half_bits(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  expo;
    logic [10:0] man;
    logic [7:0]  e;
    sgn  = h[15];
    expo = h[14:10];
    man  = {1'b0, h[9:0]};
    if (expo == 5'd0) begin
      if (man == 11'd0) return {sgn, 31'd0};
      e = FP16_BIAS_ADJ + 8'd1;
      while (!man[10]) begin
        man = man << 1;
        e   = e - 8'd1;
      end
      return {sgn, e, man[9:0], 13'd0};
    end
    if (expo == 5'h1f) return {sgn, 8'hff, man[9:0], 13'd0};
    return {sgn, {3'd0, expo} + FP16_BIAS_ADJ, man[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] widen_e4m3_bits(input logic [7:0] q);
    logic       sgn;
    logic [3:0] expo;
    logic [3:0] man;
    logic [7:0] e;
    sgn  = q[7];
    expo = q[6:3];
    man  = {1'b0, q[2:0]};
    if (expo == 4'd0) begin
      if (man == 4'd0) return {sgn, 31'd0};
      e = E4M3_BIAS_ADJ + 8'd1;
      while (!man[3]) begin
        man = man << 1;
        e   = e - 8'd1;
      end
      return {sgn, e, man[2:0], 20'd0};
    end
    if (expo == 4'hf && man[2:0] == 3'h7) return FP32_NAN_CODE;
    return {sgn, {4'd0, expo} + E4M3_BIAS_ADJ, man[2:0], 20'd0};
  endfunction

  function automatic logic [31:0] narrow_to_half_bits(input logic [31:0] f);
    logic       sgn;
    logic [7:0] expo;
    logic [7:0] e;
    sgn  = f[31];
    expo = f[30:23];
    e    = expo - FP16_BIAS_ADJ;
    if (expo == 8'd0) return {16'd0, sgn, 15'd0};
    if (expo == 8'hff)
      return {16'd0, sgn, 5'h1f, (f[22:0] != 23'd0) ? 10'h200 : 10'd0};
    if (expo >= FP16_EXP_OVF) return {16'd0, sgn, 5'h1f, 10'd0};
    if (expo <= FP16_BIAS_ADJ) return {16'd0, sgn, 15'd0};
    return {16'd0, sgn, e[4:0], f[22:13]};
  endfunction

  function automatic logic [31:0] narrow_to_e4m3_bits(input logic [31:0] f);
    logic       sgn;
    logic [7:0] expo;
    logic [7:0] e;
    logic [2:0] m3;
    sgn  = f[31];
    expo = f[30:23];
    e    = expo - E4M3_BIAS_ADJ;
    m3   = f[22:20];
    if (expo == 8'd0) return {24'd0, sgn, 7'd0};
    if (expo == 8'hff) return {24'd0, sgn, 7'h7f};
    if (expo > E4M3_EXP_TOP) return {24'd0, sgn, 4'hf, 3'h6};
    if (expo <= E4M3_BIAS_ADJ) return {24'd0, sgn, 7'd0};
    if (expo == E4M3_EXP_TOP && m3 > 3'h6) m3 = 3'h6;
    return {24'd0, sgn, e[3:0], m3};
  endfunction

  function automatic logic [31:0] converted_bits(input logic act, input logic [1:0] fmt,
                                                 input logic [31:0] v);
    if (act == ACT_WIDEN) begin
      case (fmt)
        FMT_FP16: return widen_half_bits(v[15:0]);
        FMT_BF16: return {v[15:0], 16'd0};
        FMT_E4M3: return widen_e4m3_bits(v[7:0]);
        default:  return v;
      endcase
    end
    case (fmt)
      FMT_FP16: return narrow_to_half_bits(v);
      FMT_BF16: return {16'd0, v[31:16]};
      FMT_E4M3: return narrow_to_e4m3_bits(v);
      default:  return v;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (awaited_conversions.size() == 0) begin
          if (faults < 10)
            $display("ERROR %0t: unexpected result %08h", $realtime, out_result_bits);
          faults = faults + 1;
        end else begin
          oldest = awaited_conversions.pop_front();
          if (oldest.converted !== out_result_bits) begin
            if (faults < 10)
              $display("ERROR %0t: action %0d format %0d operand %08h: expected %08h got %08h",
                       $realtime, oldest.action, oldest.format, oldest.operand,
                       oldest.converted, out_result_bits);
            faults = faults + 1;
          end
        end
      end
      if (start && !busy)
        awaited_conversions.push_back({in_action, in_format, in_value_bits,
                                       converted_bits(in_action, in_format, in_value_bits)});
      outstanding = awaited_conversions.size();
    end
  end

endmodule

// ----- bench/float_format_converter_top_test.sv -----
// Testbench top for the float format converter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module float_format_converter_top_test;
  import ffc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [1:0]  in_format;
  logic [31:0] in_value_bits;
  logic        out_strobe;
  logic [31:0] out_result_bits;
  int          fault_count;
  int          results_pending;

  float_format_converter_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_format       (in_format),
    .in_value_bits   (in_value_bits),
    .out_strobe      (out_strobe),
    .out_result_bits (out_result_bits)
  );

  conversion_checker u_conv_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_format       (in_format),
    .in_value_bits   (in_value_bits),
    .out_strobe      (out_strobe),
    .out_result_bits (out_result_bits),
    .fault_count     (fault_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic issue_conversion(input logic act, input logic [1:0] fmt,
                                  input logic [31:0] val, input bit may_idle);
    @(negedge clk);
    start         <= 1'b1;
    in_action     <= act;
    in_format     <= fmt;
    in_value_bits <= val;
    do @(posedge clk); while (busy);
    if (may_idle) begin
      while ($urandom_range(99) < 24) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    wait (results_pending == 0);
  endtask

  function automatic logic [31:0] pick_operand(input logic act);
    logic [7:0] expo;
    if (act == ACT_WIDEN || $urandom_range(3) == 0) return $urandom;
    case ($urandom_range(9))
      0:       expo = 8'd0;
      1:       expo = 8'hff;
      default: expo = 8'($urandom_range(140, 105));
    endcase
    return {1'($urandom), expo, 23'($urandom)};
  endfunction

  logic       rnd_action;
  logic [1:0] rnd_format;

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_action     = 1'b0;
    in_format     = 2'd0;
    in_value_bits = 32'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue_conversion(ACT_WIDEN,  FMT_FP32, 32'hdead_beef, 1);
    issue_conversion(ACT_WIDEN,  FMT_FP16, 32'h0000_0000, 1);
    issue_conversion(ACT_WIDEN,  FMT_FP16, 32'h0000_0001, 1);
    issue_conversion(ACT_WIDEN,  FMT_FP16, 32'hffff_83ff, 1);
    issue_conversion(ACT_WIDEN,  FMT_FP16, 32'h0000_7bff, 1);
    issue_conversion(ACT_WIDEN,  FMT_FP16, 32'h0000_fc00, 1);
    issue_conversion(ACT_WIDEN,  FMT_FP16, 32'h1234_7e01, 1);
    issue_conversion(ACT_WIDEN,  FMT_BF16, 32'h1234_bf80, 1);
    issue_conversion(ACT_WIDEN,  FMT_E4M3, 32'h0000_0001, 1);
    issue_conversion(ACT_WIDEN,  FMT_E4M3, 32'hffff_ff87, 1);
    issue_conversion(ACT_WIDEN,  FMT_E4M3, 32'h0000_0078, 1);
    issue_conversion(ACT_WIDEN,  FMT_E4M3, 32'h0000_00fe, 1);
    issue_conversion(ACT_WIDEN,  FMT_E4M3, 32'h0000_007f, 1);
    issue_conversion(ACT_WIDEN,  FMT_E4M3, 32'hffff_ffff, 1);
    issue_conversion(ACT_NARROW, FMT_FP32, 32'h0000_0000, 1);
    issue_conversion(ACT_NARROW, FMT_FP16, 32'h7fc0_0001, 1);
    issue_conversion(ACT_NARROW, FMT_FP16, 32'hff80_0000, 1);
    issue_conversion(ACT_NARROW, FMT_FP16, 32'h4780_0000, 1);
    issue_conversion(ACT_NARROW, FMT_FP16, 32'hb800_0000, 1);
    issue_conversion(ACT_NARROW, FMT_FP16, 32'h807f_ffff, 1);
    issue_conversion(ACT_NARROW, FMT_FP16, 32'h477f_ffff, 1);
    issue_conversion(ACT_NARROW, FMT_BF16, 32'hc049_0fdb, 1);
    issue_conversion(ACT_NARROW, FMT_E4M3, 32'hff80_0000, 1);
    issue_conversion(ACT_NARROW, FMT_E4M3, 32'h7fc0_0000, 1);
    issue_conversion(ACT_NARROW, FMT_E4M3, 32'h43f0_0000, 1);
    issue_conversion(ACT_NARROW, FMT_E4M3, 32'hc400_0000, 1);
    issue_conversion(ACT_NARROW, FMT_E4M3, 32'h3c7f_ffff, 1);
    issue_conversion(ACT_NARROW, FMT_E4M3, 32'h3c80_0000, 1);
    drain_results();

    for (int n = 0; n < 1000; n++) begin
      rnd_action = 1'($urandom);
      rnd_format = 2'($urandom);
      issue_conversion(rnd_action, rnd_format, pick_operand(rnd_action), n < 300 || n >= 550);
      if (n == 700) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fault_count == 0 && results_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ffc_pkg.sv
rtl/core/float_format_converter_top.sv
bench/conversion_checker.sv
bench/float_format_converter_top_test.sv
